// ===== rtl/cubic_bezier_ease_assert.svh =====
// assertion macros for the cubic bezier ease block
// no dependencies; define ASSERT_OFF to drop all checks
`ifndef CUBIC_BEZIER_EASE_ASSERT_SVH
`define CUBIC_BEZIER_EASE_ASSERT_SVH
`ifndef ASSERT_OFF
`define CBE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cubic_bezier_ease assertion failed");
`define CBE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("cubic_bezier_ease assertion failed");
`else
`define CBE_ASSERT(lbl, clk, rst_n, prop)
`define CBE_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/cbe_pkg.sv =====
// shared constants, types and command structs for cubic_bezier_ease
// no dependencies
package cbe_pkg;
    localparam int FRAC_BITS        = 16;
    localparam int NEWTON_STEPS_DEF = 5;
    localparam int T_W   = FRAC_BITS + 1;
    localparam int M_W   = 20;
    localparam int P_W   = 24;
    localparam int S_W   = 28;
    localparam int DA_W  = 27;
    localparam int E_W   = 29;
    localparam int D_W   = 30;
    localparam int NUM_W = E_W + FRAC_BITS;
    localparam int ADDR_W = 5;
    localparam logic [T_W-1:0] ONE = T_W'(1) << FRAC_BITS;

    typedef enum logic [3:0] {
        OP_UU, OP_TT, OP_UT, OP_B1, OP_B2, OP_B3,
        OP_S1, OP_S2, OP_D1, OP_D2, OP_D3
    } t_op;

    typedef enum logic [2:0] {
        REG_X1, REG_Y1, REG_X2, REG_Y2, REG_FLOOR
    } t_reg;

    typedef struct packed {
        logic [16:0]        x1;
        logic signed [18:0] y1;
        logic [16:0]        x2;
        logic signed [18:0] y2;
        logic [15:0]        slope_floor;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic op_en;
        t_op  op;
        logic sel_y;
        logic ed;
        logic div_start;
        logic div_step;
        logic upd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic stop;
    } t_sts;
endpackage

// ===== rtl/cbe_if.sv =====
// valid/ready channel interfaces for input and result words
// depends on nothing
interface cbe_in_if;
    logic               valid;
    logic               ready;
    logic signed [18:0] progress;
    modport source (output valid, output progress, input ready);
    modport sink (input valid, input progress, output ready);
endinterface

interface cbe_out_if;
    logic               valid;
    logic               ready;
    logic signed [18:0] eased;
    modport source (output valid, output eased, input ready);
    modport sink (input valid, input eased, output ready);
endinterface

// ===== rtl/cbe_cfg.sv =====
// apb register file holding the control points and the slope floor
// depends on cbe_pkg
module cbe_cfg import cbe_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output t_cfg                o_cfg
);
    t_cfg r_cfg;
    t_reg w_idx;

    assign w_idx  = t_reg'(paddr[4:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x1          <= 17'd16384;
            r_cfg.y1          <= 19'sd16384;
            r_cfg.x2          <= 17'd49152;
            r_cfg.y2          <= 19'sd49152;
            r_cfg.slope_floor <= 16'd7;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_X1:    r_cfg.x1          <= pwdata[16:0];
                REG_Y1:    r_cfg.y1          <= pwdata[18:0];
                REG_X2:    r_cfg.x2          <= pwdata[16:0];
                REG_Y2:    r_cfg.y2          <= pwdata[18:0];
                REG_FLOOR: r_cfg.slope_floor <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_X1:    prdata = {15'd0, r_cfg.x1};
            REG_Y1:    prdata = {13'd0, r_cfg.y1};
            REG_X2:    prdata = {15'd0, r_cfg.x2};
            REG_Y2:    prdata = {13'd0, r_cfg.y2};
            REG_FLOOR: prdata = {16'd0, r_cfg.slope_floor};
            default:   prdata = 32'd0;
        endcase
    end
endmodule

// ===== rtl/cbe_dp.sv =====
// datapath: shared multiplier, accumulators, bit-serial divider, t update
// depends on cbe_pkg
module cbe_dp import cbe_pkg::*; (
    input  logic               i_clk,
    input  t_cfg               i_cfg,
    input  t_cmd               i_cmd,
    input  logic signed [18:0] i_progress,
    output t_sts               o_sts,
    output logic signed [18:0] o_eased
);
    logic [T_W-1:0]          r_x, r_t;
    logic signed [P_W-1:0]   r_uu, r_tt, r_ut, r_b1, r_b2, r_b3;
    logic signed [S_W-1:0]   r_s;
    logic signed [DA_W-1:0]  r_da;
    logic signed [E_W-1:0]   r_e;
    logic signed [D_W-1:0]   r_d;
    logic [NUM_W-1:0]        r_num;
    logic [D_W-1:0]          r_rem, r_div;
    logic                    r_qneg;
    logic signed [18:0]      r_eased;

    logic [T_W-1:0]          w_u, w_x0;
    logic signed [M_W-1:0]   w_ma, w_mb, w_a1, w_a2;
    logic signed [2*M_W-1:0] w_prod;
    logic signed [P_W-1:0]   w_p;
    logic signed [S_W-1:0]   w_ps, w_p3;
    logic signed [DA_W-1:0]  w_pd;
    logic [E_W-1:0]          w_mag_e;
    logic [D_W-1:0]          w_mag_d;
    logic [D_W:0]            w_rem_sh, w_diff;
    logic signed [NUM_W:0]   w_q;
    logic signed [NUM_W+1:0] w_tn;
    logic [T_W-1:0]          w_tc;
    logic signed [E_W-1:0]   w_ysum;
    logic signed [18:0]      w_y;

    assign w_u  = ONE - r_t;
    assign w_a1 = i_cmd.sel_y ? M_W'(i_cfg.y1) : $signed(M_W'(i_cfg.x1));
    assign w_a2 = i_cmd.sel_y ? M_W'(i_cfg.y2) : $signed(M_W'(i_cfg.x2));

    always_comb begin
        if (i_progress < 0)
            w_x0 = '0;
        else if (i_progress > $signed({2'b00, ONE}))
            w_x0 = ONE;
        else
            w_x0 = i_progress[T_W-1:0];
    end

    always_comb begin
        case (i_cmd.op)
            OP_UU: begin w_ma = $signed(M_W'(w_u));  w_mb = $signed(M_W'(w_u)); end
            OP_TT: begin w_ma = $signed(M_W'(r_t));  w_mb = $signed(M_W'(r_t)); end
            OP_UT: begin w_ma = $signed(M_W'(w_u));  w_mb = $signed(M_W'(r_t)); end
            OP_B1: begin w_ma = r_uu[M_W-1:0];       w_mb = $signed(M_W'(r_t)); end
            OP_B2: begin w_ma = $signed(M_W'(w_u));  w_mb = r_tt[M_W-1:0];      end
            OP_B3: begin w_ma = r_tt[M_W-1:0];       w_mb = $signed(M_W'(r_t)); end
            OP_S1: begin w_ma = r_b1[M_W-1:0];       w_mb = w_a1;               end
            OP_S2: begin w_ma = r_b2[M_W-1:0];       w_mb = w_a2;               end
            OP_D1: begin w_ma = r_uu[M_W-1:0];       w_mb = w_a1;               end
            OP_D2: begin w_ma = r_ut[M_W-1:0];       w_mb = w_a2 - w_a1;        end
            OP_D3: begin
                w_ma = r_tt[M_W-1:0];
                w_mb = $signed(M_W'(ONE)) - w_a2;
            end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    // round half up then floor shift
    assign w_prod = w_ma * w_mb + $signed((2*M_W)'(1) << (FRAC_BITS - 1));
    assign w_p    = w_prod[FRAC_BITS+P_W-1:FRAC_BITS];
    assign w_ps   = S_W'(w_p);
    assign w_p3   = w_ps + (w_ps <<< 1);
    assign w_pd   = DA_W'(w_p);

    assign w_mag_e = r_e[E_W-1] ? E_W'(-r_e) : E_W'(r_e);
    assign w_mag_d = r_d[D_W-1] ? D_W'(-r_d) : D_W'(r_d);
    assign o_sts.stop = (w_mag_d < D_W'(i_cfg.slope_floor)) || (r_d == '0);

    assign w_rem_sh = {r_rem, r_num[NUM_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_div};

    assign w_q  = r_qneg ? -$signed({1'b0, r_num}) : $signed({1'b0, r_num});
    assign w_tn = $signed((NUM_W+2)'(r_t)) - (NUM_W+2)'(w_q);
    always_comb begin
        if (w_tn < 0)
            w_tc = '0;
        else if (w_tn > $signed((NUM_W+2)'(ONE)))
            w_tc = ONE;
        else
            w_tc = w_tn[T_W-1:0];
    end

    assign w_ysum = E_W'(r_s) + E_W'(r_b3);
    always_comb begin
        if (w_ysum < -$signed(E_W'(ONE)))
            w_y = -$signed(19'(ONE));
        else if (w_ysum > $signed(E_W'(ONE) << 1))
            w_y = $signed(19'(ONE) << 1);
        else
            w_y = w_ysum[18:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= w_x0;
            r_t <= w_x0;
        end
        if (i_cmd.op_en) begin
            case (i_cmd.op)
                OP_UU: r_uu <= w_p;
                OP_TT: r_tt <= w_p;
                OP_UT: r_ut <= w_p;
                OP_B1: r_b1 <= w_p;
                OP_B2: r_b2 <= w_p;
                OP_B3: r_b3 <= w_p;
                OP_S1: r_s  <= w_p3;
                OP_S2: r_s  <= r_s + w_p3;
                OP_D1: r_da <= w_pd;
                OP_D2: r_da <= r_da + (w_pd <<< 1);
                OP_D3: r_da <= r_da + w_pd;
                default: begin
                end
            endcase
        end
        if (i_cmd.ed) begin
            r_e <= E_W'(r_s) + E_W'(r_b3) - $signed(E_W'(r_x));
            r_d <= D_W'(r_da) + (D_W'(r_da) <<< 1);
        end
        if (i_cmd.div_start) begin
            r_num  <= {w_mag_e, FRAC_BITS'(0)};
            r_div  <= w_mag_d;
            r_rem  <= '0;
            r_qneg <= r_e[E_W-1] ^ r_d[D_W-1];
        end else if (i_cmd.div_step) begin
            if (!w_diff[D_W]) begin
                r_rem <= w_diff[D_W-1:0];
                r_num <= {r_num[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh[D_W-1:0];
                r_num <= {r_num[NUM_W-2:0], 1'b0};
            end
        end
        if (i_cmd.upd)
            r_t <= w_tc;
        if (i_cmd.out_load)
            r_eased <= w_y;
    end

    assign o_eased = r_eased;
endmodule

// ===== rtl/cbe_ctrl.sv =====
// controller: sequences multiplies, newton steps, division and output
// depends on cbe_pkg and cubic_bezier_ease_assert.svh
`include "cubic_bezier_ease_assert.svh"
module cbe_ctrl import cbe_pkg::*; #(
    parameter int STEPS = NEWTON_STEPS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam int SW = $clog2(STEPS + 1);
    localparam int CW = $clog2(NUM_W);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_ED   = 7'b0000100,
        S_CHK  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_UPD  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state        r_state, n_state;
    t_op           r_op, n_op;
    logic          r_sel_y, n_sel_y;
    logic [SW-1:0] r_step, n_step;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ov, n_ov;
    logic          w_acc, w_oload;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign w_acc       = i_in_valid && o_in_ready;
    assign w_oload     = (r_state == S_OUT) && (!r_ov || i_out_ready);

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_sel_y = r_sel_y;
        n_step  = r_step;
        n_cnt   = r_cnt;
        n_ov    = r_ov;
        o_cmd   = '0;
        o_cmd.op    = r_op;
        o_cmd.sel_y = r_sel_y;
        if (r_ov && i_out_ready)
            n_ov = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    o_cmd.load = 1'b1;
                    n_step  = '0;
                    n_op    = OP_UU;
                    n_sel_y = 1'b0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.op_en = 1'b1;
                if (r_sel_y && r_op == OP_S2)
                    n_state = S_OUT;
                else if (r_op == OP_D3)
                    n_state = S_ED;
                else
                    n_op = t_op'(r_op + 4'd1);
            end
            S_ED: begin
                o_cmd.ed = 1'b1;
                n_state  = S_CHK;
            end
            S_CHK: begin
                if (i_sts.stop) begin
                    n_op    = OP_UU;
                    n_sel_y = 1'b1;
                    n_state = S_MUL;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(NUM_W - 1))
                    n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_op   = OP_UU;
                n_step = r_step + SW'(1);
                if (r_step == SW'(STEPS - 1))
                    n_sel_y = 1'b1;
                n_state = S_MUL;
            end
            S_OUT: begin
                if (w_oload) begin
                    o_cmd.out_load = 1'b1;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_UU;
            r_sel_y <= 1'b0;
            r_step  <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_sel_y <= n_sel_y;
            r_step  <= n_step;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
    end

    `CBE_ASSERT(a_acc_starts, i_clk, i_rst_n, w_acc |=> r_state == S_MUL && !r_sel_y)
    `CBE_ASSERT(a_div_bound, i_clk, i_rst_n, r_state == S_DIV |-> r_cnt < CW'(NUM_W))
    `CBE_ASSERT(a_upd_next, i_clk, i_rst_n, r_state == S_UPD |=> r_state == S_MUL && r_op == OP_UU)
    `CBE_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !r_ov && r_state == S_IDLE)
endmodule

// ===== rtl/cubic_bezier_ease.sv =====
// top level of the cubic bezier easing evaluator
// depends on cbe_pkg, cbe_if, cbe_cfg, cbe_ctrl, cbe_dp
//
// channel  direction  payload               handshake
// i_in     in         progress  19b signed  valid/ready
// o_out    out        eased     19b signed  valid/ready
// apb      in         5 regs at 4*i         psel/penable/pwrite, pready=1
//
// one word at a time with NEWTON_STEPS newton steps per word, fewer on early
// stop; each newton step is 11 multiplies on one shared multiplier plus a
// bit-serial divider that forms a 45-bit quotient
// reset is synchronous active low and restores register defaults
// a finished word waits in the output register while the next word is taken
module cubic_bezier_ease import cbe_pkg::*; #(
    parameter int NEWTON_STEPS = NEWTON_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cbe_in_if.sink            i_in,
    cbe_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    cbe_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    cbe_ctrl #(.STEPS(NEWTON_STEPS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    cbe_dp u_dp (
        .i_clk      (i_clk),
        .i_cfg      (w_cfg),
        .i_cmd      (w_cmd),
        .i_progress (i_in.progress),
        .o_sts      (w_sts),
        .o_eased    (o_out.eased)
    );
endmodule

// ===== tb/sv/cubic_bezier_ease_tb.sv =====
// self-checking testbench for cubic_bezier_ease: apb register setup, random
// progress words, cycle-free prediction of the eased value
// depends on cbe_pkg, cbe_if and the cubic_bezier_ease rtl
`timescale 1ns / 1ps

module cubic_bezier_ease_tb import cbe_pkg::*; ();

    localparam longint Q1 = 65536;
    localparam int WATCHDOG = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    cbe_in_if in_ch();
    cbe_out_if out_ch();

    cubic_bezier_ease DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    longint cx1, cy1, cx2, cy2, cfloor;
    logic signed [18:0] pending_progress[$];
    logic signed [18:0] eased_expected[$];
    int send_idle_pct = 19, recv_idle_pct = 61;
    bit hold_send = 1'b0;
    bit timed_out = 1'b0;
    int errors = 0;
    int quiet_cycles = 0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.progress = '0;
        out_ch.ready = 1'b0;
    end

    function automatic longint qmul(longint a, longint b);
        return (a * b + Q1 / 2) >>> 16;
    endfunction

    function automatic longint curve_at(longint a1, longint a2, longint t);
        longint u, uu, tt;
        u = Q1 - t;
        uu = qmul(u, u);
        tt = qmul(t, t);
        return 3 * qmul(qmul(uu, t), a1) + 3 * qmul(qmul(u, tt), a2) + qmul(tt, t);
    endfunction

    function automatic longint curve_slope(longint a1, longint a2, longint t);
        longint u;
        u = Q1 - t;
        return 3 * (qmul(qmul(u, u), a1) + 2 * qmul(qmul(u, t), a2 - a1)
                    + qmul(qmul(t, t), Q1 - a2));
    endfunction

    function automatic logic signed [18:0] ease_of(logic signed [18:0] p);
        longint x, t, e, d, ad, y;
        x = p;
        if (x < 0) x = 0;
        if (x > Q1) x = Q1;
        t = x;
        for (int i = 0; i < NEWTON_STEPS_DEF; i++) begin
            e = curve_at(cx1, cx2, t) - x;
            d = curve_slope(cx1, cx2, t);
            ad = d < 0 ? -d : d;
            if (ad < cfloor || d == 0) break;
            t = t - (e * Q1) / d;
            if (t < 0) t = 0;
            if (t > Q1) t = Q1;
        end
        y = curve_at(cy1, cy2, t);
        if (y < -Q1) y = -Q1;
        if (y > 2 * Q1) y = 2 * Q1;
        return y[18:0];
    endfunction

    task automatic reg_write(t_reg r, logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * int'(r)); pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (r)
            REG_X1: cx1 = v[16:0];
            REG_Y1: cy1 = longint'($signed(v[18:0]));
            REG_X2: cx2 = v[16:0];
            REG_Y2: cy2 = longint'($signed(v[18:0]));
            default: cfloor = v[15:0];
        endcase
    endtask

    task automatic set_curve(longint x1, longint y1, longint x2, longint y2, longint fl);
        reg_write(REG_X1, 32'(x1));
        reg_write(REG_Y1, 32'(y1));
        reg_write(REG_X2, 32'(x2));
        reg_write(REG_Y2, 32'(y2));
        reg_write(REG_FLOOR, 32'(fl));
    endtask

    task automatic drain();
        wait (pending_progress.size() == 0 && eased_expected.size() == 0 && !in_ch.valid);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic push_random(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            if (r == 0) pending_progress.push_back(19'($urandom));
            else if (r == 1) pending_progress.push_back(19'($urandom_range(0, 4) * 16384));
            else pending_progress.push_back(19'($urandom_range(0, 65536)));
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_progress.size() != 0 && !hold_send
                        && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_ch.progress <= pending_progress[0];
                    eased_expected.push_back(ease_of(pending_progress.pop_front()));
                    in_ch.valid <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (out_ch.valid && out_ch.ready) begin
                if (eased_expected.size() == 0) begin
                    $error("eased: unexpected word %0d", out_ch.eased);
                    errors++;
                end else if (out_ch.eased !== eased_expected[0]) begin
                    $error("eased: expected %0d actual %0d", eased_expected[0], out_ch.eased);
                    errors++;
                    void'(eased_expected.pop_front());
                end else begin
                    void'(eased_expected.pop_front());
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG && !timed_out) begin
            timed_out = 1'b1;
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        cx1 = 16384; cy1 = 16384; cx2 = 49152; cy2 = 49152; cfloor = 7;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed with reset curve
        pending_progress.push_back(-19'sd131072);
        pending_progress.push_back(-19'sd1);
        pending_progress.push_back(19'sd0);
        pending_progress.push_back(19'sd1);
        pending_progress.push_back(19'sd32768);
        pending_progress.push_back(19'sd65535);
        pending_progress.push_back(19'sd65536);
        pending_progress.push_back(19'sd65537);
        pending_progress.push_back(19'sd131072);
        pending_progress.push_back(-19'sd262144);
        pending_progress.push_back(19'sd262143);
        drain();
        // extreme control points, zero floor gives zero-slope stop
        set_curve(0, -65536, 0, 131072, 0);
        for (int i = 0; i <= 8; i++) pending_progress.push_back(19'(i * 8192));
        drain();
        set_curve(65536, 131072, 65536, -65536, 65535);
        pending_progress.push_back(19'sd16384);
        pending_progress.push_back(19'sd50000);
        pending_progress.push_back(19'sd65536);
        drain();
        set_curve(65536, -65536, 0, -65536, 1);
        push_random(200);
        // pause sender until all results are back
        repeat (3000) @(posedge i_clk);
        hold_send = 1'b1;
        wait (eased_expected.size() == 0);
        hold_send = 1'b0;
        drain();
        send_idle_pct = 61; recv_idle_pct = 19;
        set_curve($urandom_range(0, 65536), $urandom_range(0, 196608) - 65536,
                  $urandom_range(0, 65536), $urandom_range(0, 196608) - 65536,
                  $urandom_range(0, 64));
        push_random(200);
        drain();
        send_idle_pct = 0; recv_idle_pct = 0;
        set_curve(17000, 131072, 48000, -65536, 7);
        push_random(125);
        drain();
        set_curve($urandom_range(0, 65536), $urandom_range(0, 196608) - 65536,
                  $urandom_range(0, 65536), $urandom_range(0, 196608) - 65536,
                  $urandom_range(0, 65535));
        push_random(100);
        drain();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
